// File: rtl/pcrel_pkg.sv
// shared constants, types and an encode helper for the pc-relative relocator
package pcrel_pkg;

    localparam int MAX_SOURCE = 256;
    localparam int SRC_W      = $clog2(MAX_SOURCE + 1);
    localparam int CFG_MAX_W  = 9;
    localparam int LIM_W      = (SRC_W > CFG_MAX_W) ? SRC_W : CFG_MAX_W;
    localparam int CLONE_W    = 11;
    localparam int POS_W      = 8;
    localparam int MAX_WORDS  = 5;
    localparam int IDX_W      = $clog2(MAX_WORDS);
    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 64;

    localparam logic [ADDR_W-1:0] REG_BASE_ADDRESS     = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_MAX_SOURCE_COUNT = ADDR_W'(8);
    localparam logic [CFG_MAX_W-1:0] MAX_COUNT_RESET   = CFG_MAX_W'(256);

    localparam logic [31:0] MASK_ADR     = 32'h9F00_0000;
    localparam logic [31:0] OP_ADRP      = 32'h9000_0000;
    localparam logic [31:0] OP_ADR       = 32'h1000_0000;
    localparam logic [31:0] MASK_BRANCH  = 32'hFC00_0000;
    localparam logic [31:0] OP_B         = 32'h1400_0000;
    localparam logic [31:0] OP_BL        = 32'h9400_0000;
    localparam logic [31:0] OP_RET       = 32'hD65F_03C0;
    localparam logic [31:0] OP_LDR_LIT64 = 32'h5800_0000;
    localparam logic [31:0] OP_BR_X16    = 32'hD61F_0200;
    localparam logic [31:0] OP_BLR_X16   = 32'hD63F_0200;
    localparam logic [18:0] LIT_OFS_MASK = 19'h7FFFF;
    localparam logic [4:0]  REG_X16      = 5'd16;

    typedef logic [31:0] t_word;
    typedef t_word [MAX_WORDS-1:0] t_word_list;

    function automatic t_word lit_load(input logic [4:0] rd, input logic [18:0] ofs_words);
        lit_load = OP_LDR_LIT64 | {8'b0, ofs_words & LIT_OFS_MASK, 5'b0} | {27'b0, rd};
    endfunction

endpackage

// File: rtl/pcrel_if.sv
// valid/ready channel interfaces for instruction input and clone word output
interface pcrel_in_if;
    import pcrel_pkg::*;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;
    logic        first;

    modport source (output valid, output instruction, output first, input ready);
    modport sink (input valid, input instruction, input first, output ready);
endinterface

interface pcrel_out_if;
    import pcrel_pkg::*;
    logic               valid;
    logic               ready;
    logic [31:0]        out_word;
    logic [POS_W-1:0]   source_position;
    logic [CLONE_W-1:0] clone_position;
    logic               last_of_run;
    logic               function_end;

    modport source (output valid, output out_word, output source_position,
                    output clone_position, output last_of_run, output function_end,
                    input ready);
    modport sink (input valid, input out_word, input source_position,
                  input clone_position, input last_of_run, input function_end,
                  output ready);
endinterface

// File: rtl/aarch64_pc_relative_relocator.sv
// top level: aarch64 pc-relative instruction relocator
//
//  channel  | direction | handshake       | payload
//  i_in     | in        | valid/ready     | instruction, first
//  o_out    | out       | valid/ready     | out_word, source/clone position, marks
//  apb      | in        | psel/penable    | base_address (0x0), max_source_count (0x8)
//
//  an emitted item gives 1 to 5 clone words (1 for a plain word, 4 for adr/adrp/b, 5 for bl);
//  one clone word leaves the result register per cycle while o_out.ready is high; items giving no words leave none
//  the next item is taken in the cycle the last word of the current one transfers
//  a stalled output holds the result register and blocks input; reset is synchronous
//  and clears the counters, the ended mark, the configuration registers and the output valid flag and word index
module aarch64_pc_relative_relocator
    import pcrel_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    pcrel_in_if.sink           i_in,
    pcrel_out_if.source        o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    // configuration and running state
    logic [63:0]          r_base;
    logic [CFG_MAX_W-1:0] r_max;
    logic [63:0]          r_pc;
    logic [SRC_W-1:0]     r_src;
    logic [CLONE_W-1:0]   r_clone;
    logic                 r_ended;

    // result register
    logic                 r_valid;
    logic [IDX_W-1:0]     r_idx;
    t_word_list           r_words;
    logic [CNT_W-1:0]     r_cnt;
    logic [POS_W-1:0]     r_opos_src;
    logic [CLONE_W-1:0]   r_opos_clone;
    logic                 r_stop;

    logic                 cfg_wr;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_last;

    logic [SRC_W-1:0]     eff_src;
    logic [CLONE_W-1:0]   eff_clone;
    logic                 eff_ended;
    logic [63:0]          cur_pc;
    logic [LIM_W-1:0]     limit;
    logic [LIM_W-1:0]     src_ext;
    logic                 at_limit;
    logic                 last_src;
    logic                 emit;

    logic [31:0]          w;
    logic                 is_adrp;
    logic                 is_adr;
    logic                 is_b;
    logic                 is_bl;
    logic                 is_ret;
    logic [63:0]          adrp_off;
    logic [63:0]          adr_off;
    logic [63:0]          br_off;
    logic [63:0]          add_base;
    logic [63:0]          add_off;
    logic [63:0]          target;
    t_word_list           n_words;
    logic [CNT_W-1:0]     n_cnt;
    logic                 n_stop;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = paddr[3] ? {{(DATA_W-CFG_MAX_W){1'b0}}, r_max} : r_base;

    assign out_last = (r_idx == IDX_W'(r_cnt - CNT_W'(1)));
    assign out_xfer = o_out.valid && o_out.ready;
    assign i_in.ready = !r_valid || (o_out.ready && out_last);
    assign in_xfer  = i_in.valid && i_in.ready;

    assign o_out.valid           = r_valid;
    assign o_out.out_word        = r_words[r_idx];
    assign o_out.source_position = r_opos_src;
    assign o_out.clone_position  = r_opos_clone;
    assign o_out.last_of_run     = out_last;
    assign o_out.function_end    = out_last && r_stop;

    // counters as seen by this item, after a possible restart
    always_comb begin
        eff_src   = i_in.first ? '0 : r_src;
        eff_clone = i_in.first ? '0 : r_clone;
        eff_ended = i_in.first ? 1'b0 : r_ended;
        cur_pc    = i_in.first ? r_base : r_pc;
        limit     = (LIM_W'(r_max) < LIM_W'(MAX_SOURCE)) ? LIM_W'(r_max) : LIM_W'(MAX_SOURCE);
        src_ext   = LIM_W'(eff_src);
        at_limit  = (src_ext >= limit);
        last_src  = ((src_ext + LIM_W'(1)) >= limit);
        emit      = !eff_ended && !at_limit;
    end

    // decode and expansion
    always_comb begin
        w        = i_in.instruction;
        is_adrp  = (w & MASK_ADR) == OP_ADRP;
        is_adr   = (w & MASK_ADR) == OP_ADR;
        is_b     = (w & MASK_BRANCH) == OP_B;
        is_bl    = (w & MASK_BRANCH) == OP_BL;
        is_ret   = (w == OP_RET);
        adrp_off = {{31{w[23]}}, w[23:5], w[30:29], 12'b0};
        adr_off  = {{43{w[23]}}, w[23:5], w[30:29]};
        br_off   = {{36{w[25]}}, w[25:0], 2'b0};
        add_base = is_adrp ? {cur_pc[63:12], 12'b0} : cur_pc;
        add_off  = is_adrp ? adrp_off : (is_adr ? adr_off : br_off);
        target   = add_base + add_off;

        n_words  = '0;
        n_cnt    = CNT_W'(1);
        n_stop   = last_src;
        if (is_adrp || is_adr) begin
            n_words[0] = lit_load(w[4:0], 19'd2);
            n_words[1] = OP_B | 32'd3;
            n_words[2] = target[31:0];
            n_words[3] = target[63:32];
            n_cnt      = CNT_W'(4);
        end else if (is_b) begin
            n_words[0] = lit_load(REG_X16, 19'd2);
            n_words[1] = OP_BR_X16;
            n_words[2] = target[31:0];
            n_words[3] = target[63:32];
            n_cnt      = CNT_W'(4);
            n_stop     = 1'b1;
        end else if (is_bl) begin
            n_words[0] = lit_load(REG_X16, 19'd3);
            n_words[1] = OP_BLR_X16;
            n_words[2] = OP_B | 32'd3;
            n_words[3] = target[31:0];
            n_words[4] = target[63:32];
            n_cnt      = CNT_W'(5);
        end else begin
            n_words[0] = w;
            n_stop     = last_src || is_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_max   <= MAX_COUNT_RESET;
            r_pc    <= '0;
            r_src   <= '0;
            r_clone <= '0;
            r_ended <= 1'b0;
        end else if (in_xfer) begin
            r_src   <= emit ? eff_src + SRC_W'(1) : eff_src;
            r_clone <= emit ? eff_clone + CLONE_W'(n_cnt) : eff_clone;
            r_ended <= eff_ended || at_limit || (emit && n_stop);
            r_pc    <= emit ? cur_pc + 64'd4 : cur_pc;
        end else if (cfg_wr) begin
            if (paddr[3] == REG_MAX_SOURCE_COUNT[3]) begin
                r_max <= pwdata[CFG_MAX_W-1:0];
            end else begin
                r_base <= pwdata;
                r_pc   <= pwdata + {{(64-SRC_W-2){1'b0}}, r_src, 2'b00};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (in_xfer && emit) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (out_xfer && out_last) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (out_xfer) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_words      <= n_words;
            r_cnt        <= n_cnt;
            r_opos_src   <= eff_src[POS_W-1:0];
            r_opos_clone <= eff_clone;
            r_stop       <= n_stop;
        end
    end

    // no new item while words of the current one remain
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !out_last) |-> !i_in.ready)
        else $error("input ready while result words remain");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (CNT_W'(r_idx) < r_cnt))
        else $error("word index beyond run length");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !out_last) |=> (r_valid && r_idx == IDX_W'($past(r_idx) + IDX_W'(1))))
        else $error("run broken before last word");

    a_end_sets_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && emit && n_stop) |=> r_ended)
        else $error("ended mark not set after function end");

    a_ended_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_ended && !i_in.first) |=> !(r_valid && r_idx == '0 && !$past(r_valid)))
        else $error("result after function end");

endmodule

// File: verif/aarch64_pc_relative_relocator_tb.sv
// testbench for the aarch64 pc-relative relocator: directed table, random functions, scoreboard
module aarch64_pc_relative_relocator_tb;
    import pcrel_pkg::*;

    localparam int N_ROWS       = 31;
    localparam int RANDOM_ITEMS = 440;
    localparam int CYCLE_LIMIT  = 300000;

    typedef enum {ROW_ITEM, ROW_SET_BASE, ROW_SET_LIMIT} t_row_kind;
    typedef enum {PICK_BODY, PICK_NOISY, PICK_END} t_pick_kind;
    typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HEAVY} t_rx_mode;

    typedef struct {
        t_row_kind   kind;
        logic [63:0] value;
        logic        first;
        bit          chk;
        int          exp_n;
        logic [31:0] exp_w0;
    } t_stim_row;

    typedef struct {
        logic [31:0]        word;
        logic [POS_W-1:0]   spos;
        logic [CLONE_W-1:0] cpos;
        logic               last;
        logic               fend;
    } t_clone_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pcrel_in_if  in_ch ();
    pcrel_out_if out_ch ();

    aarch64_pc_relative_relocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // relocator state as predicted
    logic [63:0]          pred_base;
    logic [CFG_MAX_W-1:0] pred_max;
    int                   src_cnt;
    int                   cln_cnt;
    bit                   pred_ended;

    t_clone_word clone_words_due[$];
    t_stim_row   directed_rows [0:N_ROWS-1];

    int       mismatches = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_span = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp);
        if (got !== exp)
            report($sformatf("%s got %h expected %h", name, got, exp));
    endtask

    task automatic relocate_item(input logic [31:0] w, input logic first,
                                 output int n, output logic [31:0] w0);
        logic [31:0] words [MAX_WORDS];
        logic [63:0] pc;
        logic [63:0] tgt;
        logic [63:0] ofs;
        int          limit;
        bit          stop;
        t_clone_word cw;
        n  = 0;
        w0 = '0;
        if (first) begin
            src_cnt    = 0;
            cln_cnt    = 0;
            pred_ended = 1'b0;
        end
        if (pred_ended)
            return;
        limit = (pred_max < MAX_SOURCE) ? int'(pred_max) : MAX_SOURCE;
        if (src_cnt >= limit) begin
            pred_ended = 1'b1;
            return;
        end
        pc   = pred_base + 64'(src_cnt * 4);
        stop = 1'b0;
        if ((w & MASK_ADR) == OP_ADRP || (w & MASK_ADR) == OP_ADR) begin
            ofs = {{43{w[23]}}, w[23:5], w[30:29]};
            tgt = ((w & MASK_ADR) == OP_ADRP) ? ((pc & ~64'hFFF) + (ofs << 12)) : (pc + ofs);
            words[0] = OP_LDR_LIT64 | {8'b0, 19'd2, w[4:0]};
            words[1] = OP_B | 32'd3;
            words[2] = tgt[31:0];
            words[3] = tgt[63:32];
            n = 4;
        end else if ((w & MASK_BRANCH) == OP_B) begin
            tgt = pc + {{36{w[25]}}, w[25:0], 2'b00};
            words[0] = OP_LDR_LIT64 | {8'b0, 19'd2, REG_X16};
            words[1] = OP_BR_X16;
            words[2] = tgt[31:0];
            words[3] = tgt[63:32];
            n    = 4;
            stop = 1'b1;
        end else if ((w & MASK_BRANCH) == OP_BL) begin
            tgt = pc + {{36{w[25]}}, w[25:0], 2'b00};
            words[0] = OP_LDR_LIT64 | {8'b0, 19'd3, REG_X16};
            words[1] = OP_BLR_X16;
            words[2] = OP_B | 32'd3;
            words[3] = tgt[31:0];
            words[4] = tgt[63:32];
            n = 5;
        end else begin
            words[0] = w;
            n    = 1;
            stop = (w == OP_RET);
        end
        if (src_cnt + 1 >= limit)
            stop = 1'b1;
        for (int k = 0; k < n; k++) begin
            cw.word = words[k];
            cw.spos = POS_W'(src_cnt);
            cw.cpos = CLONE_W'(cln_cnt);
            cw.last = (k == n - 1);
            cw.fend = (k == n - 1) && stop;
            clone_words_due.push_back(cw);
        end
        src_cnt += 1;
        cln_cnt += n;
        if (stop)
            pred_ended = 1'b1;
        w0 = words[0];
    endtask

    function automatic logic [31:0] pick_instr(input t_pick_kind kind);
        logic [31:0] w;
        if (kind == PICK_END)
            return ($urandom_range(0, 1) != 0) ? OP_RET : (($urandom & ~MASK_BRANCH) | OP_B);
        case ($urandom_range(0, 11))
            0, 1: w = ($urandom & ~MASK_ADR) | OP_ADRP;
            2, 3: w = ($urandom & ~MASK_ADR) | OP_ADR;
            4, 5: w = ($urandom & ~MASK_BRANCH) | OP_BL;
            6: w = ($urandom & ~MASK_BRANCH) | OP_B;
            7: w = OP_RET;
            default: w = $urandom;
        endcase
        // body words must not end the function early
        if (kind == PICK_BODY && ((w & MASK_BRANCH) == OP_B || w == OP_RET))
            w = w ^ 32'h8000_0000;
        return w;
    endfunction

    task automatic send_item(input logic [31:0] w, input logic first,
                             output int n, output logic [31:0] w0);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid       = 1'b1;
        in_ch.instruction = w;
        in_ch.first       = first;
        do @(posedge i_clk); while (!in_ch.ready);
        relocate_item(w, first, n, w0);
    endtask

    task automatic idle_in();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        burst_left  = 0;
    endtask

    task automatic wait_drained();
        while (clone_words_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [63:0] value);
        logic [63:0] v;
        v = (addr == REG_MAX_SOURCE_COUNT) ? {55'b0, value[CFG_MAX_W-1:0]} : value;
        idle_in();
        wait_drained();
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        check_field($sformatf("readback of register %h", addr), prdata, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (addr == REG_MAX_SOURCE_COUNT)
            pred_max = v[CFG_MAX_W-1:0];
        else
            pred_base = v;
    endtask

    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_span = $urandom_range(20, 80);
        end
        rx_span--;
        case (rx_mode)
            RX_OPEN: out_ch.ready = 1'b1;
            RX_RANDOM: out_ch.ready = ($urandom_range(0, 3) != 0);
            RX_PERIODIC: out_ch.ready = (rx_span % 4 != 0);
            default: out_ch.ready = ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge i_clk) begin : clone_word_check
        t_clone_word due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (clone_words_due.size() == 0) begin
                report($sformatf("transfer of %h with nothing expected", out_ch.out_word));
            end else begin
                due = clone_words_due.pop_front();
                check_field("out_word", out_ch.out_word, due.word);
                check_field("source_position", out_ch.source_position, due.spos);
                check_field("clone_position", out_ch.clone_position, due.cpos);
                check_field("last_of_run", out_ch.last_of_run, due.last);
                check_field("function_end", out_ch.function_end, due.fend);
            end
        end
    end

    initial begin
        int          n;
        int          len;
        int          items_done;
        bit          long_done;
        logic        fst;
        logic [31:0] w;
        logic [31:0] w0;
        logic [63:0] lim;
        logic [63:0] base;
        in_ch.valid       = 1'b0;
        in_ch.instruction = '0;
        in_ch.first       = 1'b0;
        out_ch.ready      = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        i_rst_n           = 1'b0;
        pred_base         = '0;
        pred_max          = MAX_COUNT_RESET;
        src_cnt           = 0;
        cln_cnt           = 0;
        pred_ended        = 1'b0;
        items_done        = 0;
        long_done         = 1'b0;

        directed_rows = '{
            '{ROW_SET_BASE,  64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_ITEM,      64'hD503_201F, 1'b1, 1'b1, 1, 32'hD503_201F},
            '{ROW_ITEM,      64'hF07F_FFE5, 1'b0, 1'b1, 4, 32'h5800_0045},
            '{ROW_ITEM,      64'h1080_001F, 1'b0, 1'b1, 4, 32'h5800_005F},
            '{ROW_ITEM,      64'h70FF_FFE0, 1'b0, 1'b1, 4, 32'h5800_0040},
            '{ROW_ITEM,      64'h9600_0000, 1'b0, 1'b1, 5, 32'h5800_0070},
            '{ROW_ITEM,      64'h95FF_FFFF, 1'b0, 1'b1, 5, 32'h5800_0070},
            '{ROW_ITEM,      64'hD65F_03C0, 1'b0, 1'b1, 1, 32'hD65F_03C0},
            '{ROW_ITEM,      64'hFFFF_FFFF, 1'b0, 1'b1, 0, 32'h0},
            '{ROW_ITEM,      64'h0000_0000, 1'b1, 1'b1, 1, 32'h0000_0000},
            '{ROW_ITEM,      64'h15FF_FFFF, 1'b0, 1'b1, 4, 32'h5800_0050},
            '{ROW_ITEM,      64'h9400_0000, 1'b0, 1'b1, 0, 32'h0},
            '{ROW_SET_LIMIT, 64'd0, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_SET_BASE,  64'h0, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_ITEM,      64'hD503_201F, 1'b1, 1'b1, 0, 32'h0},
            '{ROW_ITEM,      64'h0000_0000, 1'b0, 1'b1, 0, 32'h0},
            '{ROW_SET_LIMIT, 64'd1, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_ITEM,      64'h9400_0001, 1'b1, 1'b1, 5, 32'h5800_0070},
            '{ROW_ITEM,      64'hD503_201F, 1'b0, 1'b1, 0, 32'h0},
            '{ROW_SET_LIMIT, 64'd2, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_ITEM,      64'hD503_201F, 1'b1, 1'b1, 1, 32'hD503_201F},
            '{ROW_ITEM,      64'h9000_0000, 1'b0, 1'b1, 4, 32'h5800_0040},
            '{ROW_ITEM,      64'h9000_0000, 1'b0, 1'b1, 0, 32'h0},
            '{ROW_SET_LIMIT, 64'd511, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_SET_BASE,  64'h8000_0000_0000_0000, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_ITEM,      64'h17FF_FFFF, 1'b1, 1'b1, 4, 32'h5800_0050},
            '{ROW_ITEM,      64'hFFFF_FFFF, 1'b1, 1'b1, 1, 32'hFFFF_FFFF},
            '{ROW_ITEM,      64'hD503_201F, 1'b0, 1'b1, 1, 32'hD503_201F},
            '{ROW_SET_LIMIT, 64'd2, 1'b0, 1'b0, 0, 32'h0},
            '{ROW_ITEM,      64'hD503_201F, 1'b0, 1'b1, 0, 32'h0},
            '{ROW_SET_LIMIT, 64'd256, 1'b0, 1'b0, 0, 32'h0}
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            case (directed_rows[i].kind)
                ROW_SET_BASE: write_reg(REG_BASE_ADDRESS, directed_rows[i].value);
                ROW_SET_LIMIT: write_reg(REG_MAX_SOURCE_COUNT, directed_rows[i].value);
                default: begin
                    send_item(directed_rows[i].value[31:0], directed_rows[i].first, n, w0);
                    if (directed_rows[i].chk && (n != directed_rows[i].exp_n ||
                            (n > 0 && w0 !== directed_rows[i].exp_w0)))
                        report($sformatf("row %0d predicts %0d words from %h", i, n, w0));
                end
            endcase
        end

        while (items_done < RANDOM_ITEMS) begin
            // one function at the full source limit
            if (!long_done && items_done >= 150) begin
                write_reg(REG_MAX_SOURCE_COUNT, ($urandom_range(0, 1) != 0) ? 64'd256 : 64'd511);
                write_reg(REG_BASE_ADDRESS, {$urandom, $urandom});
                for (int k = 0; k < MAX_SOURCE + 3; k++) begin
                    send_item(pick_instr(PICK_BODY), k == 0, n, w0);
                    items_done++;
                end
                long_done = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 7))
                    0: lim = 64'd0;
                    1: lim = 64'd1;
                    2: lim = 64'd511;
                    3: lim = 64'd256;
                    4: lim = 64'($urandom);
                    default: lim = 64'($urandom_range(1, 40));
                endcase
                case ($urandom_range(0, 3))
                    0: base = 64'h0;
                    1: base = '1;
                    2: base = 64'hFFFF_FFFF_FFFF_F000 | 64'($urandom_range(0, 4095));
                    default: base = {$urandom, $urandom};
                endcase
                write_reg(REG_MAX_SOURCE_COUNT, lim);
                write_reg(REG_BASE_ADDRESS, base);
            end else if ($urandom_range(0, 7) == 0) begin
                idle_in();
                wait_drained();
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                fst = (k == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 24) == 0);
                if (k == len - 1 && $urandom_range(0, 2) != 0)
                    w = pick_instr(PICK_END);
                else
                    w = pick_instr(($urandom_range(0, 24) == 0) ? PICK_NOISY : PICK_BODY);
                send_item(w, fst, n, w0);
                items_done++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_item($urandom, 1'b0, n, w0);
                items_done++;
            end
        end

        idle_in();
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && clone_words_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/pcrel_pkg.sv
rtl/pcrel_if.sv
rtl/aarch64_pc_relative_relocator.sv
verif/aarch64_pc_relative_relocator_tb.sv
